/* hw/rtl/alpha_over_pixel_merge_assert.svh */
// Assertion macros used by the alpha-over pixel merge checker.
`ifndef ALPHA_OVER_PIXEL_MERGE_ASSERT_SVH
`define ALPHA_OVER_PIXEL_MERGE_ASSERT_SVH

// Plain property, checked at every clock edge outside reset.
`define AOPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When cond holds, expr must hold at the next clock edge.
`define AOPM_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error(msg);

`endif

/* hw/rtl/aopm_pkg.sv */
// Shared types and constants of the alpha-over pixel merge.
package aopm_pkg;

  // Width of one color or alpha component.
  localparam int unsigned PixW = 8;

  // Stream word widths.
  localparam int unsigned InTdataW  = 8 * PixW;
  localparam int unsigned OutTdataW = 4 * PixW;

  // Per-stage advance enables that the top level hands to every lane.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } aopm_ctl_t;

endpackage

/* hw/rtl/aopm_lane.sv */
// One color lane: weighted sum of two channels, then exact division by full scale.
module aopm_lane #(
  parameter int unsigned FULL_SCALE = 255
) (
  input  logic                                       clk_i,
  input  aopm_pkg::aopm_ctl_t                        ctl_i,
  input  logic [aopm_pkg::PixW-1:0]                  top_i,
  input  logic [aopm_pkg::PixW-1:0]                  bottom_i,
  input  logic [aopm_pkg::PixW-1:0]                  wt_top_i,
  input  logic [$clog2(FULL_SCALE+1)-1:0]            wt_bot_i,
  output logic [aopm_pkg::PixW-1:0]                  blend_o
);
  import aopm_pkg::*;

  localparam int unsigned FsW   = $clog2(FULL_SCALE + 1);
  localparam int unsigned Lg    = $clog2(FULL_SCALE);
  // The numerator stays below 256 * FULL_SCALE.
  localparam int unsigned NumW  = PixW + Lg;
  localparam int unsigned Sh    = NumW + Lg;
  localparam int unsigned RecW  = NumW + 2;
  localparam int unsigned ProdW = NumW + RecW;
  // Rounded-up reciprocal; exact for every numerator below 2**NumW.
  localparam logic [63:0] Rec64 =
    ((64'd1 << Sh) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
  localparam logic [RecW-1:0] Rec = Rec64[RecW-1:0];

  logic [2*PixW-1:0]    p_top_q;
  logic [PixW+FsW-1:0]  p_bot_q;
  logic [NumW-1:0]      num;
  logic [ProdW-1:0]     prod_q;
  logic [PixW-1:0]      blend_q;

  // Stage one: the two weighted products.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) begin
      p_top_q <= top_i * wt_top_i;
      p_bot_q <= (PixW+FsW)'(bottom_i) * (PixW+FsW)'(wt_bot_i);
    end
  end

  // Stage two: numerator times the reciprocal.
  assign num = NumW'(p_top_q) + NumW'(p_bot_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en2) begin
      prod_q <= ProdW'(num) * ProdW'(Rec);
    end
  end

  // Stage three: the quotient is the high part of the product.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en3) begin
      blend_q <= prod_q[Sh +: PixW];
    end
  end

  assign blend_o = blend_q;

endmodule

/* hw/rtl/alpha_over_pixel_merge.sv */
// Top level of the alpha-over pixel merge: three color lanes and the alpha path.
//
//  channel   dir  word fields (lowest bits first)
//  s_axis    in   top r,g,b,a then bottom r,g,b,a, 8 bits each
//  m_axis    out  out r,g,b,a, 8 bits each
//
// One word is taken every cycle while the pipeline has room; its result passes through the
// product, reciprocal-multiply and quotient registers in turn and is offered once it has
// reached the quotient register.
// Reset clears only the stage valid flags. A stalled output holds its word,
// and earlier stages keep accepting until every bubble ahead is filled.
module alpha_over_pixel_merge #(
  parameter int unsigned FULL_SCALE = 255
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // top_red, top_green, top_blue, top_alpha,
  // bottom_red, bottom_green, bottom_blue, bottom_alpha
  input  logic [aopm_pkg::InTdataW-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [aopm_pkg::OutTdataW-1:0]     m_axis_tdata
);
  import aopm_pkg::*;

  localparam int unsigned FsW = $clog2(FULL_SCALE + 1);
  localparam int unsigned CapInt = (FULL_SCALE > 255) ? 255 : FULL_SCALE;
  localparam logic [PixW-1:0] AlphaCap = PixW'(CapInt);
  localparam logic [FsW-1:0]  FullW    = FsW'(FULL_SCALE);

  aopm_ctl_t        ctl;
  logic             v1_q, v2_q, v3_q;
  logic [PixW-1:0]  top_alpha, bottom_alpha;
  logic [PixW-1:0]  wt_top;
  logic [FsW-1:0]   wt_bot;
  logic [PixW:0]    alpha_sum;
  logic [PixW-1:0]  alpha_sat;
  logic [PixW-1:0]  alpha1_q, alpha2_q, alpha3_q;
  logic [PixW-1:0]  lane_out [3];

  // A stage moves on when it is empty or the stage after it moves on.
  assign ctl.en3 = !v3_q || m_axis_tready;
  assign ctl.en2 = !v2_q || ctl.en3;
  assign ctl.en1 = !v1_q || ctl.en2;
  assign s_axis_tready = ctl.en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ctl.en1) v1_q <= s_axis_tvalid;
      if (ctl.en2) v2_q <= v1_q;
      if (ctl.en3) v3_q <= v2_q;
    end
  end

  // Shared blend weights; a top alpha above full scale counts as opaque.
  assign top_alpha    = s_axis_tdata[3*PixW +: PixW];
  assign bottom_alpha = s_axis_tdata[7*PixW +: PixW];
  assign wt_top = (top_alpha > AlphaCap) ? AlphaCap : top_alpha;
  assign wt_bot = FullW - FsW'(wt_top);

  // Color lanes work side by side on red, green and blue.
  for (genvar g = 0; g < 3; g++) begin : g_lane
    aopm_lane #(
      .FULL_SCALE (FULL_SCALE)
    ) u_lane (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .top_i    (s_axis_tdata[g*PixW +: PixW]),
      .bottom_i (s_axis_tdata[(g+4)*PixW +: PixW]),
      .wt_top_i (wt_top),
      .wt_bot_i (wt_bot),
      .blend_o  (lane_out[g])
    );
  end

  // Alpha sum with saturation, delayed to line up with the lanes.
  assign alpha_sum = {1'b0, top_alpha} + {1'b0, bottom_alpha};
  assign alpha_sat = (alpha_sum > {1'b0, AlphaCap}) ? AlphaCap : alpha_sum[PixW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl.en1) alpha1_q <= alpha_sat;
    if (ctl.en2) alpha2_q <= alpha1_q;
    if (ctl.en3) alpha3_q <= alpha2_q;
  end

  // Merge the lane results and the alpha into the output word.
  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {alpha3_q, lane_out[2], lane_out[1], lane_out[0]};

endmodule

/* hw/rtl/aopm_checker.sv */
// Port-level checks of the alpha-over pixel merge, bound to the top level.
`include "alpha_over_pixel_merge_assert.svh"

module aopm_checker #(
  parameter int unsigned FULL_SCALE = 255
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [aopm_pkg::InTdataW-1:0]      s_axis_tdata,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [aopm_pkg::OutTdataW-1:0]     m_axis_tdata
);
  import aopm_pkg::*;

  localparam int unsigned CapInt = (FULL_SCALE > 255) ? 255 : FULL_SCALE;
  localparam logic [PixW-1:0] AlphaCap = PixW'(CapInt);

  logic            in_stall;
  logic            out_stall;
  logic [PixW-1:0] out_alpha;

  assign in_stall  = s_axis_tvalid && !s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_alpha = m_axis_tdata[3*PixW +: PixW];

  // A stalled result word stays offered and unchanged.
  `AOPM_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "output valid dropped while stalled")
  `AOPM_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata), "output word changed in stall")

  // A stalled input word stays offered and unchanged.
  `AOPM_ASSERT_NEXT(a_in_hold, in_stall, s_axis_tvalid && $stable(s_axis_tdata), "input word dropped")

  // With no result waiting the pipeline always has room for a word.
  `AOPM_ASSERT(a_ready_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

  // The merged alpha never exceeds the saturation cap.
  `AOPM_ASSERT(a_alpha_cap, m_axis_tvalid |-> (out_alpha <= AlphaCap), "alpha above cap")

endmodule

bind alpha_over_pixel_merge aopm_checker #(
  .FULL_SCALE (FULL_SCALE)
) u_aopm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* verif/alpha_over_pixel_merge_tb.sv */
// Self-checking stream testbench for the alpha-over pixel merge.
`timescale 1ns / 100ps

module alpha_over_pixel_merge_tb;

  localparam int unsigned FullScale = 255;
  // Cycles without any word taken at input or output before the run is declared hung.
  localparam int unsigned HangLimit = 2000;
  // Extra cycles after the last result, enough to expose a stray word.
  localparam int unsigned TailCycles = 20;
  localparam int unsigned RandomPixels = 750;
  // Idling stops once this few words are left to send.
  localparam int unsigned QuietTail = 100;

  // Input word, last field in the lowest bits.
  typedef struct packed {
    logic [7:0] bottom_alpha;
    logic [7:0] bottom_blue;
    logic [7:0] bottom_green;
    logic [7:0] bottom_red;
    logic [7:0] top_alpha;
    logic [7:0] top_blue;
    logic [7:0] top_green;
    logic [7:0] top_red;
  } pixel_pair_t;

  // Output word, last field in the lowest bits.
  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
  } blend_t;

  // A word waiting to be sent; drain_first holds it until all results are back.
  typedef struct {
    pixel_pair_t pixel;
    bit          drain_first;
  } queued_pixel_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // top_red, top_green, top_blue, top_alpha,
  // bottom_red, bottom_green, bottom_blue, bottom_alpha
  logic [aopm_pkg::InTdataW-1:0]   s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // out_red, out_green, out_blue, out_alpha
  logic [aopm_pkg::OutTdataW-1:0]  m_axis_tdata;

  queued_pixel_t pixels_to_send[$];
  blend_t        blends_due[$];

  bit          src_taken = 1'b0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  int unsigned idle_pct = 25;
  int unsigned words_sent = 0;
  int unsigned hang_count = 0;
  int unsigned fail_count = 0;

  alpha_over_pixel_merge #(
    .FULL_SCALE(FullScale)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Weighted mix of one color channel, truncating quotient.
  function automatic logic [7:0] mix_channel(logic [7:0] top, logic [7:0] bottom,
                                             longint unsigned weight);
    longint unsigned sum;
    sum = top * weight + bottom * (FullScale - weight);
    return 8'(sum / FullScale);
  endfunction

  // Composite the top pixel over the bottom one.
  function automatic blend_t blend_over(pixel_pair_t p);
    longint unsigned weight;
    longint unsigned ceiling;
    longint unsigned alpha_sum;
    blend_t r;
    // An alpha beyond full scale counts as fully opaque.
    weight = (p.top_alpha > FullScale) ? FullScale : p.top_alpha;
    ceiling = (FullScale > 255) ? 255 : FullScale;
    alpha_sum = p.top_alpha + p.bottom_alpha;
    r.out_red   = mix_channel(p.top_red, p.bottom_red, weight);
    r.out_green = mix_channel(p.top_green, p.bottom_green, weight);
    r.out_blue  = mix_channel(p.top_blue, p.bottom_blue, weight);
    r.out_alpha = 8'((alpha_sum > ceiling) ? ceiling : alpha_sum);
    return r;
  endfunction

  function automatic void queue_pixel(logic [7:0] tr, logic [7:0] tg, logic [7:0] tb,
                                      logic [7:0] ta, logic [7:0] br, logic [7:0] bg,
                                      logic [7:0] bb, logic [7:0] ba, bit drain);
    queued_pixel_t q;
    q.pixel = '{bottom_alpha: ba, bottom_blue: bb, bottom_green: bg, bottom_red: br,
                top_alpha: ta, top_blue: tb, top_green: tg, top_red: tr};
    q.drain_first = drain;
    pixels_to_send.push_back(q);
  endfunction

  // Random component, sometimes pulled toward the ends of the range.
  function automatic logic [7:0] pick_value(bit lean_to_edges);
    if (lean_to_edges && ($urandom_range(1) == 1)) begin
      case ($urandom_range(3))
        0: return 8'd0;
        1: return 8'd1;
        2: return 8'd254;
        default: return 8'd255;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Input driver: a word stays on the bus until it is taken.
  always @(negedge clk_i) begin : drive_input
    int unsigned pct;
    logic        send_now;
    if (rst_ni && !(s_axis_tvalid && !src_taken)) begin
      pct = (pixels_to_send.size() < QuietTail) ? 0 : idle_pct;
      send_now = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (pixels_to_send.size() > 0) begin
        if (pixels_to_send[0].drain_first) begin
          // Hold back until the pipeline has emptied.
          if (blends_due.size() == 0) begin
            pixels_to_send[0].drain_first = 1'b0;
            send_now = 1'b1;
          end
        end else if (pct > 0 && $urandom_range(99) < pct) begin
          src_gap = $urandom_range(5, 1) - 1;
        end else begin
          send_now = 1'b1;
        end
      end
      s_axis_tvalid <= send_now;
      if (send_now) begin
        s_axis_tdata <= pixels_to_send[0].pixel;
      end
    end
  end

  // Output ready with random stall bursts.
  always @(negedge clk_i) begin : drive_ready
    int unsigned pct;
    if (rst_ni) begin
      pct = (pixels_to_send.size() < QuietTail) ? 0 : idle_pct;
      if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else if (pct > 0 && $urandom_range(99) < pct) begin
        snk_gap = $urandom_range(5, 1) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: check results, predict for accepted words, and watch for a hang.
  always @(posedge clk_i) begin : monitor
    blend_t got;
    blend_t want;
    bit     out_taken;
    if (rst_ni) begin
      src_taken = s_axis_tvalid && s_axis_tready;
      out_taken = m_axis_tvalid && m_axis_tready;
      if (out_taken) begin
        got = m_axis_tdata;
        if (blends_due.size() == 0) begin
          $error("unexpected output word %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = blends_due.pop_front();
          check_field("out_red", want.out_red, got.out_red);
          check_field("out_green", want.out_green, got.out_green);
          check_field("out_blue", want.out_blue, got.out_blue);
          check_field("out_alpha", want.out_alpha, got.out_alpha);
        end
      end
      if (src_taken) begin
        blends_due.push_back(blend_over(pixels_to_send[0].pixel));
        void'(pixels_to_send.pop_front());
        words_sent++;
        // Change the amount of idling every so often.
        if (words_sent % 80 == 0) begin
          case ($urandom_range(3))
            0: idle_pct = 0;
            1: idle_pct = 10;
            2: idle_pct = 30;
            default: idle_pct = 60;
          endcase
        end
      end
      hang_count = (src_taken || out_taken) ? 0 : hang_count + 1;
      if (hang_count >= HangLimit) begin
        $display("alpha_over_pixel_merge_tb failed");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    bit lean;
    // Alpha extremes: transparent and opaque top, both alphas zero or full.
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd200, 8'd100, 8'd50, 8'd0, 8'd10, 8'd20, 8'd30, 8'd77, 1'b0);
    queue_pixel(8'd200, 8'd100, 8'd50, 8'd255, 8'd10, 8'd20, 8'd30, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd0, 8'd127, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd254, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd254, 8'd255, 8'd255, 8'd255, 8'd1, 1'b0);
    // Alpha sum just below and above saturation.
    queue_pixel(8'd1, 8'd2, 8'd3, 8'd100, 8'd4, 8'd5, 8'd6, 8'd154, 1'b0);
    queue_pixel(8'd1, 8'd2, 8'd3, 8'd100, 8'd4, 8'd5, 8'd6, 8'd156, 1'b0);
    queue_pixel(8'd9, 8'd8, 8'd7, 8'd200, 8'd6, 8'd5, 8'd4, 8'd255, 1'b1);
    // Alternating bit patterns on every field.
    queue_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
    queue_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
    // Truncation: mixes that land just short of a whole step.
    queue_pixel(8'd1, 8'd254, 8'd128, 8'd127, 8'd0, 8'd1, 8'd127, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd254, 8'd3, 8'd64, 8'd254, 8'd255, 8'd252, 8'd191, 1'b0);
    queue_pixel(8'd0, 8'd255, 8'd17, 8'd192, 8'd255, 8'd0, 8'd238, 8'd63, 1'b0);
    // Mostly random pixels, a part of them biased toward extreme values.
    for (int i = 0; i < RandomPixels; i++) begin
      lean = ($urandom_range(3) == 0);
      queue_pixel(pick_value(lean), pick_value(lean), pick_value(lean), pick_value(lean),
                  pick_value(lean), pick_value(lean), pick_value(lean), pick_value(lean),
                  (i == RandomPixels / 2));
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pixels_to_send.size() != 0 || blends_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("alpha_over_pixel_merge_tb passed");
    end else begin
      $display("alpha_over_pixel_merge_tb failed");
    end
    $finish;
  end

endmodule
